>>> rtl/mep_pkg.sv
// Shared types, constants and saturation helper for the Mandelbrot escape-time block.
package mep_pkg;

    localparam int FRAC_BITS  = 26;
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
    localparam int CNT_W      = 8;
    localparam int PIXEL_W    = 10;
    localparam int SPACING_W  = 21;
    localparam int CENTER_W   = 29;
    localparam int OFFSET_W   = 10;
    localparam int COORD_W    = PIXEL_W + SPACING_W + 2;
    localparam int NUM_CELLS  = 2;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 29;

    localparam int IN_TDATA_W  = ((2 * PIXEL_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((CNT_W + 1 + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_SPACING = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_RE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_IM = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = CFG_IDX_W'(4);

    localparam logic [SPACING_W-1:0]       RST_SPACING   = SPACING_W'(335544);
    localparam logic signed [CENTER_W-1:0] RST_CENTER_RE = CENTER_W'(67108864);
    localparam logic signed [CENTER_W-1:0] RST_CENTER_IM = CENTER_W'(0);
    localparam logic [OFFSET_W-1:0]        RST_OFFSET    = OFFSET_W'(400);
    localparam logic [CNT_W-1:0]           RST_LIMIT     = CNT_W'(50);

    localparam logic signed [ACC_W-1:0] ESCAPE_BOUND = ACC_W'(4) << FRAC_BITS;
    localparam logic signed [ACC_W-1:0] SAT_HI = (ACC_W'(1) << (DATA_W - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -(ACC_W'(1) << (DATA_W - 1));

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] cr;
        logic signed [DATA_W-1:0] ci;
        logic [CNT_W-1:0]         n;
    } tok_t;

    typedef struct packed {
        logic                     ov;
        logic signed [DATA_W-1:0] value;
    } sat_t;

    function automatic sat_t sat32(input logic signed [ACC_W-1:0] v);
        sat_t r;
        if (v > SAT_HI)
        begin
            r.ov    = 1'b1;
            r.value = SAT_HI[DATA_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r.ov    = 1'b1;
            r.value = SAT_LO[DATA_W-1:0];
        end
        else
        begin
            r.ov    = 1'b0;
            r.value = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/mep_coord.sv
// Maps a pixel column and row to the point c in two registered steps.
module mep_coord (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [mep_pkg::PIXEL_W-1:0]          column,
    input  logic [mep_pkg::PIXEL_W-1:0]          row,
    input  logic [mep_pkg::SPACING_W-1:0]        spacing,
    input  logic signed [mep_pkg::CENTER_W-1:0]  center_real,
    input  logic signed [mep_pkg::CENTER_W-1:0]  center_imag,
    input  logic [mep_pkg::OFFSET_W-1:0]         offset,
    output logic                                 tok_valid,
    output mep_pkg::tok_t                        tok
);

    logic signed [mep_pkg::PIXEL_W:0]   dc_re;
    logic signed [mep_pkg::PIXEL_W:0]   dc_im;
    logic signed [mep_pkg::SPACING_W:0] sp_s;
    logic signed [mep_pkg::COORD_W-1:0] prod_re_next;
    logic signed [mep_pkg::COORD_W-1:0] prod_im_next;
    logic signed [mep_pkg::COORD_W-1:0] prod_re_reg;
    logic signed [mep_pkg::COORD_W-1:0] prod_im_reg;
    logic                               a_valid_reg;
    logic signed [mep_pkg::ACC_W-1:0]   cr_full;
    logic signed [mep_pkg::ACC_W-1:0]   ci_full;
    mep_pkg::sat_t                      cr_sat;
    mep_pkg::sat_t                      ci_sat;
    mep_pkg::tok_t                      tok_next;
    mep_pkg::tok_t                      tok_reg;
    logic                               tok_valid_reg;

    always_comb
    begin
        dc_re        = signed'({1'b0, column}) - signed'({1'b0, offset});
        dc_im        = signed'({1'b0, row}) - signed'({1'b0, offset});
        sp_s         = signed'({1'b0, spacing});
        prod_re_next = mep_pkg::COORD_W'(dc_re) * mep_pkg::COORD_W'(sp_s);
        prod_im_next = mep_pkg::COORD_W'(dc_im) * mep_pkg::COORD_W'(sp_s);
    end

    always_comb
    begin
        cr_full       = mep_pkg::ACC_W'(prod_re_reg) - mep_pkg::ACC_W'(center_real);
        ci_full       = mep_pkg::ACC_W'(prod_im_reg) - mep_pkg::ACC_W'(center_imag);
        cr_sat        = mep_pkg::sat32(cr_full);
        ci_sat        = mep_pkg::sat32(ci_full);
        tok_next.done = 1'b0;
        tok_next.x    = '0;
        tok_next.y    = '0;
        tok_next.cr   = cr_sat.value;
        tok_next.ci   = ci_sat.value;
        tok_next.n    = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg   <= start;
            tok_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_re_reg <= prod_re_next;
            prod_im_reg <= prod_im_next;
        end
        if (a_valid_reg)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

endmodule

>>> rtl/mep_cell.sv
// One iteration cell: squares z in its first stage, forms z^2 + c and the escape test in its second.
module mep_cell (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  mep_pkg::tok_t                in_tok,
    input  logic [mep_pkg::CNT_W-1:0]    limit,
    output logic                         out_valid,
    output mep_pkg::tok_t                out_tok
);

    logic                              go;
    logic                              s1_valid_reg;
    mep_pkg::tok_t                     s1_tok_reg;
    mep_pkg::tok_t                     s1_tok_next;
    logic signed [mep_pkg::PROD_W-1:0] s1_xx_reg;
    logic signed [mep_pkg::PROD_W-1:0] s1_yy_reg;
    logic signed [mep_pkg::PROD_W-1:0] s1_xy_reg;
    logic signed [mep_pkg::ACC_W-1:0]  xx;
    logic signed [mep_pkg::ACC_W-1:0]  yy;
    logic signed [mep_pkg::ACC_W-1:0]  xy2;
    logic signed [mep_pkg::ACC_W-1:0]  mag;
    mep_pkg::sat_t                     nx_sat;
    mep_pkg::sat_t                     ny_sat;
    mep_pkg::tok_t                     out_tok_next;
    mep_pkg::tok_t                     out_tok_reg;
    logic                              out_valid_reg;

    // A finished token that comes around the ring is not taken up again.
    assign go = in_valid && !in_tok.done;

    always_comb
    begin
        s1_tok_next      = in_tok;
        s1_tok_next.done = (in_tok.n >= limit);
    end

    always_comb
    begin
        xx     = mep_pkg::ACC_W'(s1_xx_reg >>> mep_pkg::FRAC_BITS);
        yy     = mep_pkg::ACC_W'(s1_yy_reg >>> mep_pkg::FRAC_BITS);
        xy2    = mep_pkg::ACC_W'(s1_xy_reg >>> (mep_pkg::FRAC_BITS - 1));
        mag    = xx + yy;
        nx_sat = mep_pkg::sat32(xx - yy + mep_pkg::ACC_W'(s1_tok_reg.cr));
        ny_sat = mep_pkg::sat32(xy2 + mep_pkg::ACC_W'(s1_tok_reg.ci));

        out_tok_next = s1_tok_reg;
        if (!s1_tok_reg.done)
        begin
            if (mag >= mep_pkg::ESCAPE_BOUND)
            begin
                out_tok_next.done = 1'b1;
            end
            else
            begin
                out_tok_next.x    = nx_sat.value;
                out_tok_next.y    = ny_sat.value;
                out_tok_next.n    = s1_tok_reg.n + mep_pkg::CNT_W'(1);
                out_tok_next.done = nx_sat.ov || ny_sat.ov;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= go;
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            s1_tok_reg <= s1_tok_next;
            s1_xx_reg  <= mep_pkg::PROD_W'(in_tok.x) * mep_pkg::PROD_W'(in_tok.x);
            s1_yy_reg  <= mep_pkg::PROD_W'(in_tok.y) * mep_pkg::PROD_W'(in_tok.y);
            s1_xy_reg  <= mep_pkg::PROD_W'(in_tok.x) * mep_pkg::PROD_W'(in_tok.y);
        end
        if (s1_valid_reg)
        begin
            out_tok_reg <= out_tok_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tok   = out_tok_reg;

endmodule

>>> rtl/mandelbrot_escape_pixel.sv
// Top level of the Mandelbrot escape-time pixel engine: config registers, cell ring, result buffer.
// A pixel is first mapped to the point c; each pass through one cell of the ring is a multiply
// stage followed by an add-and-test stage, and a step that saturates ends the pixel. One pixel is
// in flight at a time; the next beat is taken the cycle after the result is loaded into the
// output register.
// rst_n clears all valid flags and loads the configuration registers with their default values.
module mandelbrot_escape_pixel (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // Fields from bit 0: column[9:0], row[19:10], zero fill.
    input  logic [mep_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // Fields from bit 0: escaped[0], iterations[8:1], zero fill.
    output logic [mep_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [mep_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [mep_pkg::SPACING_W-1:0]       spacing_reg;
    logic signed [mep_pkg::CENTER_W-1:0] center_re_reg;
    logic signed [mep_pkg::CENTER_W-1:0] center_im_reg;
    logic [mep_pkg::OFFSET_W-1:0]        offset_reg;
    logic [mep_pkg::CNT_W-1:0]           limit_reg;

    logic                                in_fire;
    logic                                busy_reg;
    logic                                busy_next;
    logic                                coord_valid;
    mep_pkg::tok_t                       coord_tok;

    logic [mep_pkg::NUM_CELLS-1:0]       ring_valid;
    mep_pkg::tok_t                       ring_tok [mep_pkg::NUM_CELLS];
    logic [mep_pkg::NUM_CELLS-1:0]       feed_valid;
    mep_pkg::tok_t                       feed_tok [mep_pkg::NUM_CELLS];

    logic                                res_valid;
    logic [mep_pkg::CNT_W-1:0]           res_n;
    logic                                out_load;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic                                out_esc_reg;
    logic [mep_pkg::CNT_W-1:0]           out_iter_reg;
    logic                                hold_valid_reg;
    logic                                hold_valid_next;
    logic [mep_pkg::CNT_W-1:0]           hold_n_reg;

    assign cfg_ready     = 1'b1;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= mep_pkg::RST_SPACING;
            center_re_reg <= mep_pkg::RST_CENTER_RE;
            center_im_reg <= mep_pkg::RST_CENTER_IM;
            offset_reg    <= mep_pkg::RST_OFFSET;
            limit_reg     <= mep_pkg::RST_LIMIT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                mep_pkg::CFG_SPACING:   spacing_reg   <= cfg_data[mep_pkg::SPACING_W-1:0];
                mep_pkg::CFG_CENTER_RE: center_re_reg <= signed'(cfg_data[mep_pkg::CENTER_W-1:0]);
                mep_pkg::CFG_CENTER_IM: center_im_reg <= signed'(cfg_data[mep_pkg::CENTER_W-1:0]);
                mep_pkg::CFG_OFFSET:    offset_reg    <= cfg_data[mep_pkg::OFFSET_W-1:0];
                mep_pkg::CFG_LIMIT:     limit_reg     <= cfg_data[mep_pkg::CNT_W-1:0];
                default:                ;
            endcase
        end
    end

    mep_coord u_coord (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (in_fire),
        .column      (s_axis_tdata[mep_pkg::PIXEL_W-1:0]),
        .row         (s_axis_tdata[2*mep_pkg::PIXEL_W-1:mep_pkg::PIXEL_W]),
        .spacing     (spacing_reg),
        .center_real (center_re_reg),
        .center_imag (center_im_reg),
        .offset      (offset_reg),
        .tok_valid   (coord_valid),
        .tok         (coord_tok)
    );

    genvar gi;
    generate
        for (gi = 0; gi < mep_pkg::NUM_CELLS; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_head
                assign feed_valid[gi] = coord_valid || ring_valid[mep_pkg::NUM_CELLS-1];
                assign feed_tok[gi]   = coord_valid ? coord_tok
                                                    : ring_tok[mep_pkg::NUM_CELLS-1];
            end
            else
            begin : g_link
                assign feed_valid[gi] = ring_valid[gi-1];
                assign feed_tok[gi]   = ring_tok[gi-1];
            end

            mep_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .in_valid  (feed_valid[gi]),
                .in_tok    (feed_tok[gi]),
                .limit     (limit_reg),
                .out_valid (ring_valid[gi]),
                .out_tok   (ring_tok[gi])
            );
        end
    endgenerate

    // At most one token is in the ring, so the finished one is picked by a plain OR.
    always_comb
    begin
        res_valid = 1'b0;
        res_n     = '0;
        for (int i = 0; i < mep_pkg::NUM_CELLS; i++)
        begin
            if (ring_valid[i] && ring_tok[i].done)
            begin
                res_valid = 1'b1;
                res_n     = res_n | ring_tok[i].n;
            end
        end
    end

    always_comb
    begin
        out_load        = !out_valid_reg || m_axis_tready;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        hold_valid_next = hold_valid_reg;
        busy_next       = busy_reg || in_fire;
        if (hold_valid_reg && out_load)
        begin
            out_valid_next  = 1'b1;
            hold_valid_next = 1'b0;
            busy_next       = 1'b0;
        end
        else if (res_valid)
        begin
            if (out_load)
            begin
                out_valid_next = 1'b1;
                busy_next      = 1'b0;
            end
            else
            begin
                hold_valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_valid_reg && out_load)
        begin
            out_iter_reg <= hold_n_reg;
            out_esc_reg  <= (hold_n_reg < limit_reg);
        end
        else if (res_valid && out_load)
        begin
            out_iter_reg <= res_n;
            out_esc_reg  <= (res_n < limit_reg);
        end
        if (res_valid && !out_load)
        begin
            hold_n_reg <= res_n;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(mep_pkg::OUT_TDATA_W - mep_pkg::CNT_W - 1){1'b0}},
                            out_iter_reg, out_esc_reg};

endmodule

>>> rtl/mep_checker.sv
// Port-level checker for the Mandelbrot escape-time pixel engine, bound to the top level.
module mep_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [mep_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Output beat dropped while stalled.");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("Output beat changed while stalled.");

    a_one_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("A second pixel was taken while one is in flight.");

    a_escape_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> m_axis_tdata[mep_pkg::CNT_W:1] != '0)
        else $error("An escaped pixel reported zero iterations.");

endmodule

bind mandelbrot_escape_pixel mep_checker u_mep_checker (.*);

>>> sim/mandelbrot_escape_pixel_test.sv
// Self-checking testbench for the Mandelbrot escape-time pixel engine.
`timescale 1ns / 1ps

module mandelbrot_escape_pixel_test;

    typedef struct packed {
        logic                      escaped;
        logic [mep_pkg::CNT_W-1:0] iterations;
    } pixel_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [mep_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready;
    logic [mep_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [mep_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [mep_pkg::CFG_DATA_W-1:0]  cfg_data;

    logic [mep_pkg::SPACING_W-1:0]       view_spacing;
    logic signed [mep_pkg::CENTER_W-1:0] view_center_re;
    logic signed [mep_pkg::CENTER_W-1:0] view_center_im;
    logic [mep_pkg::OFFSET_W-1:0]        view_offset;
    logic [mep_pkg::CNT_W-1:0]           view_limit;

    pixel_result_t escape_expected[$];
    pixel_result_t oldest_result;
    int            mismatches = 0;
    bit            tx_idle = 1'b1;
    bit            rx_idle = 1'b1;
    int            rx_hold = 0;

    mandelbrot_escape_pixel u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("TEST FAILED");
        $finish;
    end

    function automatic mep_pkg::sat_t clamp_word(input longint v);
        mep_pkg::sat_t r;
        if (v > 64'sd2147483647)
        begin
            r.ov    = 1'b1;
            r.value = 32'sh7FFF_FFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r.ov    = 1'b1;
            r.value = 32'sh8000_0000;
        end
        else
        begin
            r.ov    = 1'b0;
            r.value = v[mep_pkg::DATA_W-1:0];
        end
        return r;
    endfunction

    function automatic pixel_result_t predict_escape(input logic [mep_pkg::PIXEL_W-1:0] col,
                                                     input logic [mep_pkg::PIXEL_W-1:0] row);
        longint        step, org, pc, pr, cen_re, cen_im, four;
        longint        c_re, c_im, x, y, xx, yy;
        mep_pkg::sat_t cs_re, cs_im, nx, ny;
        int            n;
        pixel_result_t r;
        step   = longint'(view_spacing);
        org    = longint'(view_offset);
        pc     = longint'(col);
        pr     = longint'(row);
        cen_re = longint'(view_center_re);
        cen_im = longint'(view_center_im);
        four   = longint'(4) << mep_pkg::FRAC_BITS;
        cs_re  = clamp_word((pc - org) * step - cen_re);
        cs_im  = clamp_word((pr - org) * step - cen_im);
        c_re   = longint'(cs_re.value);
        c_im   = longint'(cs_im.value);
        x = 0;
        y = 0;
        n = 0;
        while (n < view_limit)
        begin
            xx = (x * x) >>> mep_pkg::FRAC_BITS;
            yy = (y * y) >>> mep_pkg::FRAC_BITS;
            if (xx + yy >= four)
                break;
            nx = clamp_word(xx - yy + c_re);
            ny = clamp_word(((x * y) >>> (mep_pkg::FRAC_BITS - 1)) + c_im);
            x  = longint'(nx.value);
            y  = longint'(ny.value);
            n++;
            if (nx.ov || ny.ov)
                break;
        end
        r.escaped    = (n < view_limit);
        r.iterations = n[mep_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic void apply_reg(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                                      input logic [mep_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            mep_pkg::CFG_SPACING:   view_spacing   = data[mep_pkg::SPACING_W-1:0];
            mep_pkg::CFG_CENTER_RE: view_center_re = data[mep_pkg::CENTER_W-1:0];
            mep_pkg::CFG_CENTER_IM: view_center_im = data[mep_pkg::CENTER_W-1:0];
            mep_pkg::CFG_OFFSET:    view_offset    = data[mep_pkg::OFFSET_W-1:0];
            mep_pkg::CFG_LIMIT:     view_limit     = data[mep_pkg::CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic signed [mep_pkg::CENTER_W-1:0] rand_center();
        if ($urandom_range(0, 4) == 0)
            return mep_pkg::CENTER_W'($urandom());
        return mep_pkg::CENTER_W'($urandom_range(0, 3 << 26) - (3 << 25));
    endfunction

    task automatic send_pixel(input int col, input int row);
        int                          gap;
        logic [mep_pkg::PIXEL_W-1:0] px_col;
        logic [mep_pkg::PIXEL_W-1:0] px_row;
        px_col = mep_pkg::PIXEL_W'(col);
        px_row = mep_pkg::PIXEL_W'(row);
        gap = tx_idle ? $urandom_range(0, 15) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= mep_pkg::IN_TDATA_W'({px_row, px_col});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        escape_expected.push_back(predict_escape(px_col, px_row));
    endtask

    task automatic send_random_pixel();
        send_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (escape_expected.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [mep_pkg::CFG_IDX_W-1:0] idx,
                             input logic [mep_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, data);
    endtask

    task automatic close_writes();
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_view(input int spacing, input int c_re, input int c_im,
                            input int offset, input int limit);
        drain();
        write_reg(mep_pkg::CFG_SPACING, mep_pkg::CFG_DATA_W'(spacing));
        write_reg(mep_pkg::CFG_CENTER_RE, mep_pkg::CFG_DATA_W'(c_re));
        write_reg(mep_pkg::CFG_CENTER_IM, mep_pkg::CFG_DATA_W'(c_im));
        write_reg(mep_pkg::CFG_OFFSET, mep_pkg::CFG_DATA_W'(offset));
        write_reg(mep_pkg::CFG_LIMIT, mep_pkg::CFG_DATA_W'(limit));
        close_writes();
    endtask

    task automatic test_default_view();
        send_pixel(400, 400);
        send_pixel(600, 400);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        send_pixel(200, 400);
        send_pixel(350, 450);
    endtask

    task automatic test_iteration_limits();
        set_view(335544, 67108864, 0, 400, 255);
        send_pixel(400, 400);
        send_pixel(650, 400);
        send_pixel(300, 300);
        set_view(335544, 67108864, 0, 400, 1);
        send_pixel(400, 400);
        send_pixel(0, 0);
        set_view(335544, 67108864, 0, 400, 0);
        send_pixel(400, 400);
        send_pixel(1023, 1023);
    endtask

    task automatic test_zero_spacing();
        set_view(0, 0, 0, 400, 40);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
        set_view(0, -(1 << 28), (1 << 28) - 1, 400, 40);
        send_pixel(512, 100);
    endtask

    task automatic test_saturation();
        set_view((1 << 21) - 1, -(1 << 28), (1 << 28) - 1, 0, 255);
        send_pixel(1023, 0);
        send_pixel(0, 1023);
        set_view((1 << 21) - 1, (1 << 28) - 1, -(1 << 28), 1023, 255);
        send_pixel(0, 0);
        send_pixel(1023, 1023);
    endtask

    task automatic test_register_masking();
        drain();
        for (int i = int'(mep_pkg::CFG_LIMIT) + 1; i < (1 << mep_pkg::CFG_IDX_W); i++)
            write_reg(mep_pkg::CFG_IDX_W'(i), mep_pkg::CFG_DATA_W'($urandom()));
        write_reg(mep_pkg::CFG_SPACING, {8'hA5, 21'd300000});
        write_reg(mep_pkg::CFG_OFFSET, {19'h5A5A5, 10'd512});
        write_reg(mep_pkg::CFG_LIMIT, {21'h1ABCDE, 8'd30});
        close_writes();
        send_pixel(512, 512);
        send_pixel(100, 900);
        send_pixel(700, 300);
    endtask

    task automatic test_backpressure();
        set_view(335544, 67108864, 0, 400, 20);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        rx_hold = 300;
        repeat (8) send_random_pixel();
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    task automatic test_random_views(input int views, input int per_view);
        int spacing, limit, pick;
        for (int v = 0; v < views; v++)
        begin
            pick    = $urandom_range(0, 3);
            spacing = (pick == 0) ? $urandom_range(0, (1 << 21) - 1)
                                  : $urandom_range(1000, 400000);
            pick    = $urandom_range(0, 9);
            limit   = (pick == 0) ? 255 : (pick == 1) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 80);
            set_view(spacing, int'(rand_center()), int'(rand_center()),
                     $urandom_range(0, 1023), limit);
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            repeat (per_view) send_random_pixel();
        end
        tx_idle = 1'b1;
        rx_idle = 1'b1;
    endtask

    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                while (rx_hold > 0)
                begin
                    @(posedge clk);
                    rx_hold--;
                end
            end
            gap = rx_idle ? $urandom_range(0, 15) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (escape_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat %h at %0t", m_axis_tdata, $realtime);
            end
            else
            begin
                oldest_result = escape_expected.pop_front();
                if (m_axis_tdata[0] !== oldest_result.escaped ||
                    m_axis_tdata[mep_pkg::CNT_W:1] !== oldest_result.iterations)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch at %0t: escaped %b/%b iterations %0d/%0d",
                                 $realtime, oldest_result.escaped, m_axis_tdata[0],
                                 oldest_result.iterations, m_axis_tdata[mep_pkg::CNT_W:1]);
                end
            end
        end
    end

    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        view_spacing   = mep_pkg::RST_SPACING;
        view_center_re = mep_pkg::RST_CENTER_RE;
        view_center_im = mep_pkg::RST_CENTER_IM;
        view_offset    = mep_pkg::RST_OFFSET;
        view_limit     = mep_pkg::RST_LIMIT;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_view();
        test_iteration_limits();
        test_zero_spacing();
        test_saturation();
        test_register_masking();
        test_backpressure();
        test_random_views(12, 72);

        drain();
        repeat (40) @(posedge clk);
        if (mismatches == 0 && escape_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
